/* sv/svf_pkg.sv */
// ----------------------------------------------------------------------------
// svf_pkg
// Shared types, constants and the quarter-wave sine function for the scalar
// V/f modulation front end.
// ----------------------------------------------------------------------------
package svf_pkg;

  localparam int unsigned SineAddrBitsDef = 10;
  localparam logic [31:0] KSqrt2   = 32'd1518500250;
  localparam logic [31:0] KInvSqrt2 = 32'd759250125;
  localparam logic [15:0] IdxOne   = 16'd32768;
  localparam logic [14:0] ThreshRst = 15'd160;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_GAIN   = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_CONT0 = 2'd0,
    MODE_DPWM  = 2'd1,
    MODE_AUTO  = 2'd2,
    MODE_CONT3 = 2'd3
  } svpwm_mode_e;

  typedef struct packed {
    logic [15:0]        volt_cmd;
    logic [15:0]        link_volt;
    logic signed [15:0] freq;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        mod_index;
    logic [15:0]        out_volt;
    logic [31:0]        phase_out;
    logic signed [15:0] sin_val;
    logic signed [15:0] cos_val;
    logic signed [15:0] alpha_ref;
    logic signed [15:0] beta_ref;
    logic               use_dpwm60;
    logic               period_done;
  } out_item_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic [15:0] volt_cmd;
    logic [15:0] link_volt;
    logic        link_zero;
    logic [31:0] phase_new;
    logic        wrap;
    logic        dpwm;
  } work_t;

  // Quarter-wave sine entry k, evaluated at elaboration only (constant table).
  function automatic logic signed [15:0] quarter_sine(int unsigned k, int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'd1686629713 * 64'(k)) >> qbits;
    x2 = (x * x) >> 30;
    // Nested Horner series up to x^13, innermost term first.
    t  = 64'd1073741824;
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd156);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd110);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd72);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd42);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd20);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd6);
    s = (x * t) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return 16'(s);
  endfunction

endpackage

/* sv/svf_front.sv */
// ----------------------------------------------------------------------------
// svf_front
// Accepts input beats, advances the phase accumulator, flags wraps and picks
// the SVPWM variant; pushes classified work into the queue.
// ----------------------------------------------------------------------------
module svf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  svf_pkg::in_item_t item_i,
  input  logic [1:0]        mode_i,
  input  logic [31:0]       gain_i,
  input  logic [14:0]       thresh_i,
  output svf_pkg::work_t    work_o,
  output logic              work_valid_o
);
  import svf_pkg::*;

  typedef enum logic { F_IDLE, F_MUL } fstate_e;

  fstate_e     state_q;
  in_item_t    item_q;
  logic [31:0] phase_q, phase_d;
  logic [47:0] prod_q;
  logic [15:0] mag;
  logic [31:0] stepv;
  logic [32:0] sum;
  logic        neg;
  logic        dp;

  assign mag = item_i.freq[15] ? 16'(-item_i.freq) : item_i.freq;
  assign neg = item_q.freq[15];
  assign stepv = prod_q[47:16];

  // Add or subtract the step with carry/borrow out.
  always_comb begin
    if (neg) sum = {1'b0, phase_q} - {1'b0, stepv};
    else     sum = {1'b0, phase_q} + {1'b0, stepv};
    phase_d = sum[31:0];
    unique case (svpwm_mode_e'(mode_i))
      MODE_DPWM: dp = 1'b1;
      MODE_AUTO: dp = $signed(item_q.freq) > $signed({1'b0, thresh_i});
      default:   dp = 1'b0;
    endcase
  end

  // Multiply when a beat is taken, then update the phase in F_MUL.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      phase_q      <= '0;
      work_valid_o <= 1'b0;
    end else begin
      work_valid_o <= 1'b0;
      unique case (state_q)
        F_IDLE: if (take_i) begin
          item_q  <= item_i;
          prod_q  <= 48'(mag) * 48'(gain_i);
          state_q <= F_MUL;
        end
        F_MUL: begin
          phase_q <= phase_d;
          work_o.volt_cmd  <= item_q.volt_cmd;
          work_o.link_volt <= item_q.link_volt;
          work_o.link_zero <= item_q.link_volt == '0;
          work_o.phase_new <= phase_d;
          work_o.wrap      <= sum[32];
          work_o.dpwm      <= dp;
          work_valid_o     <= 1'b1;
          state_q          <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

/* sv/svf_back.sv */
// ----------------------------------------------------------------------------
// svf_back
// Divides for the modulation index, scales the reachable voltage, looks up
// sine and cosine and forms alpha and beta references.
// ----------------------------------------------------------------------------
module svf_back #(
  parameter int unsigned SINE_ADDR_BITS = svf_pkg::SineAddrBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               work_valid_i,
  input  svf_pkg::work_t     work_i,
  output logic               work_ready_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output svf_pkg::out_item_t res_o
);
  import svf_pkg::*;

  localparam int unsigned QBits = SINE_ADDR_BITS - 2;
  localparam int unsigned QLen  = 1 << QBits;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_V1, B_V2, B_TRIG, B_SCALE, B_OUT
  } bstate_e;

  // Constant quarter-wave table.
  function automatic logic signed [15:0] rom_at(logic [QBits:0] k);
    logic signed [15:0] tab [QLen+1];
    for (int i = 0; i <= QLen; i++) tab[i] = quarter_sine(i, QBits);
    return tab[k];
  endfunction

  function automatic logic signed [15:0] lookup(logic [SINE_ADDR_BITS-1:0] a);
    logic [1:0]       quad;
    logic [QBits-1:0] off;
    logic signed [15:0] v;
    quad = a[SINE_ADDR_BITS-1 -: 2];
    off  = a[QBits-1:0];
    if (quad[0]) v = rom_at((QBits+1)'(QLen) - {1'b0, off});
    else         v = rom_at({1'b0, off});
    return quad[1] ? -v : v;
  endfunction

  bstate_e     state_q;
  work_t       w_q;
  logic [47:0] num_q;     // dividend shift register
  logic [31:0] den_q;
  logic [5:0]  cnt_q;
  logic [47:0] quo_q;
  logic [15:0] idx_q;
  logic [31:0] lv_q;
  logic [63:0] vp_q;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [48:0] rem_try;
  logic [48:0] rem_q;
  logic signed [32:0] alpha_p;
  logic signed [32:0] beta_p;

  assign work_ready_o = state_q == B_IDLE;
  assign addr = w_q.phase_new[31 -: SINE_ADDR_BITS];
  assign rem_try = {rem_q[47:0], num_q[47]} - {17'd0, den_q};

  // Full-width index times cosine and sine.
  assign alpha_p = $signed({1'b0, idx_q}) * res_o.cos_val;
  assign beta_p  = $signed({1'b0, idx_q}) * res_o.sin_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: if (work_valid_i) begin
          w_q   <= work_i;
          num_q <= 48'(work_i.volt_cmd) * 48'(KSqrt2);
          den_q <= {1'b0, work_i.link_volt, 15'd0};
          rem_q <= '0;
          cnt_q <= '0;
          state_q <= B_DIV;
        end
        // Restoring divide, one quotient bit per cycle.
        B_DIV: begin
          num_q <= {num_q[46:0], 1'b0};
          if (!rem_try[48]) begin
            rem_q <= rem_try;
            quo_q <= {quo_q[46:0], 1'b1};
          end else begin
            rem_q <= {rem_q[47:0], num_q[47]};
            quo_q <= {quo_q[46:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd47) state_q <= B_V1;
        end
        B_V1: begin
          if (w_q.link_zero || quo_q > 48'(IdxOne)) idx_q <= IdxOne;
          else idx_q <= quo_q[15:0];
          state_q <= B_V2;
        end
        B_V2: begin
          lv_q <= 32'(w_q.link_volt) * 32'(idx_q);
          state_q <= B_TRIG;
        end
        B_TRIG: begin
          vp_q <= 64'(lv_q) * 64'(KInvSqrt2);
          res_o.sin_val <= lookup(addr);
          res_o.cos_val <= lookup(addr + SINE_ADDR_BITS'(QLen));
          state_q <= B_SCALE;
        end
        B_SCALE: begin
          res_o.mod_index   <= idx_q;
          res_o.out_volt    <= vp_q[60:45];
          res_o.phase_out   <= w_q.phase_new;
          res_o.alpha_ref   <= alpha_p[30:15];
          res_o.beta_ref    <= beta_p[30:15];
          res_o.use_dpwm60  <= w_q.dpwm;
          res_o.period_done <= w_q.wrap;
          res_valid_o <= 1'b1;
          state_q <= B_OUT;
        end
        B_OUT: if (res_ready_i) begin
          res_valid_o <= 1'b0;
          state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

/* sv/svf_queue.sv */
// ----------------------------------------------------------------------------
// svf_queue
// Small FIFO between the front and the back.
// ----------------------------------------------------------------------------
module svf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  svf_pkg::work_t wdata_i,
  input  logic           rd_i,
  output svf_pkg::work_t rdata_o,
  output logic           valid_o,
  output logic [1:0]     count_o
);
  import svf_pkg::*;

  work_t      mem_q [FifoDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign rdata_o = mem_q[rp_q];
  assign valid_o = cnt_q != '0;
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

endmodule

/* sv/scalar_vf_modulation_front.sv */
// ----------------------------------------------------------------------------
// scalar_vf_modulation_front
// V/f modulation front end: index, reachable voltage, phase, sin/cos, refs.
// ----------------------------------------------------------------------------
// Usage: push one beat per control tick (volt_cmd, link_volt, freq) while
// full is low. A front stage multiplies |freq| by the gain register and
// updates the phase, then hands work to a two-entry queue. The back stage
// takes it from the queue when idle, runs a restoring divider for the
// index, then the steps B_V1, B_V2, B_TRIG and B_SCALE of clamping,
// multiplies and table lookup. The front can accept a new beat while the
// back still works on the last one, and one more beat may wait in the
// queue meanwhile. Results wait on the output until popped; while the
// receiver stalls the back holds its result, the queue keeps one beat and
// full stays high. Reset clears the phase to zero, mode to continuous, gain
// to zero, threshold to 160. Configuration writes are taken whenever
// cfg_valid_i is high and must only be issued while no beat is in flight.
// ----------------------------------------------------------------------------
module scalar_vf_modulation_front #(
  parameter int unsigned SINE_ADDR_BITS = svf_pkg::SineAddrBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  svf_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output svf_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import svf_pkg::*;

  logic [1:0]  mode_q;
  logic [31:0] gain_q;
  logic [14:0] thresh_q;
  logic        busy_q;
  logic        take;
  work_t       fw, qw;
  logic        fw_valid, q_valid, b_ready, res_valid;
  logic [1:0]  q_cnt;

  assign cfg_ready_o = 1'b1;
  assign full  = busy_q || q_cnt != 2'd0;
  assign take  = push && !full;
  assign empty = !res_valid;

  // Hold the configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0; gain_q <= '0; thresh_q <= ThreshRst;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_GAIN:   gain_q   <= cfg_data_i;
        REG_THRESH: thresh_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Hold off input while the front is busy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else if (take) busy_q <= 1'b1;
    else if (fw_valid) busy_q <= 1'b0;
  end

  svf_front u_front (
    .clk_i, .rst_ni, .take_i(take), .item_i(in_item_i),
    .mode_i(mode_q), .gain_i(gain_q), .thresh_i(thresh_q),
    .work_o(fw), .work_valid_o(fw_valid)
  );

  svf_queue u_queue (
    .clk_i, .rst_ni, .wr_i(fw_valid), .wdata_i(fw),
    .rd_i(q_valid && b_ready), .rdata_o(qw), .valid_o(q_valid), .count_o(q_cnt)
  );

  svf_back #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_back (
    .clk_i, .rst_ni, .work_valid_i(q_valid), .work_i(qw), .work_ready_o(b_ready),
    .res_valid_o(res_valid), .res_ready_i(pop), .res_o(out_item_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt != 2'd3) else $error("queue overflow");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> full) else $error("front took beat while busy");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.mod_index <= IdxOne) else $error("index out of range");

endmodule
